/* rtl/core/tcms_pkg.sv */
// Shared types, codes and the microcode table of the three-class message scheduler.
`timescale 1ns / 1ps

package tcms_pkg;

   // Sizing
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NUM_CLASSES     = 3;
   localparam int CLS_W           = 2;
   localparam int ID_W            = 16;
   localparam int DATA_W          = 64;
   localparam int TAG_W           = 3 * ID_W;
   localparam int CNT_W           = 6;
   localparam int STEP_W          = 4;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   // Budget register
   localparam logic [CNT_W-1:0] BUDGET_RESET = 6'd8;
   localparam logic [CNT_W-1:0] BUDGET_CAP   = 6'd32;
   localparam logic             REG_FRAME_BUDGET = 1'b0;

   // Transaction modes
   localparam logic [1:0] MODE_ENQUEUE    = 2'd0;
   localparam logic [1:0] MODE_DUMP       = 2'd1;
   localparam logic [1:0] MODE_MARCH      = 2'd2;
   localparam logic [1:0] MODE_INTERLEAVE = 2'd3;

   // Message classes
   localparam logic [CLS_W-1:0] CLS_URGENT  = 2'd0;
   localparam logic [CLS_W-1:0] CLS_EXPRESS = 2'd1;
   localparam logic [CLS_W-1:0] CLS_MEDIA   = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_DELIVERED = 2'd0;
   localparam logic [1:0] ST_ACCEPTED  = 2'd1;
   localparam logic [1:0] ST_DROPPED   = 2'd2;
   localparam logic [1:0] ST_NONE      = 2'd3;

   // Sequencer state
   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // Micro-operations
   typedef enum logic [1:0] {
      UOP_POP,      // pop head of cls if non-empty (and under budget when asked)
      UOP_ROUND,    // start of an interleave round: stop if budget reached
      UOP_LOOP,     // end of an interleave round: repeat if it delivered anything
      UOP_FINISH    // close the transaction
   } uop_type;

   typedef struct packed {
      uop_type           op;
      logic [CLS_W-1:0]  cls;
      logic              use_budget;
      logic [STEP_W-1:0] jmp_hit;
      logic [STEP_W-1:0] jmp_miss;
   } uword_type;

   // Program entry points
   localparam logic [STEP_W-1:0] STEP_DUMP   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_MARCH  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_ROUND  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_LOOP   = 4'd11;
   localparam logic [STEP_W-1:0] STEP_FINISH = 4'd12;

   // Control store: one word per step
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{op: UOP_FINISH, cls: CLS_URGENT, use_budget: 1'b0,
            jmp_hit: STEP_FINISH, jmp_miss: STEP_FINISH};
      case (step)
         // dump: drain urgent
         4'd0: w = '{UOP_POP, CLS_URGENT, 1'b0, 4'd0, STEP_FINISH};
         // march: strict priority under budget
         4'd1: w = '{UOP_POP, CLS_URGENT, 1'b1, 4'd1, 4'd2};
         4'd2: w = '{UOP_POP, CLS_EXPRESS, 1'b1, 4'd2, 4'd3};
         4'd3: w = '{UOP_POP, CLS_MEDIA, 1'b1, 4'd3, STEP_FINISH};
         // interleave: 3 urgent, 2 express, 1 media per round
         4'd4: w = '{UOP_ROUND, CLS_URGENT, 1'b0, 4'd5, STEP_FINISH};
         4'd5: w = '{UOP_POP, CLS_URGENT, 1'b0, 4'd6, 4'd6};
         4'd6: w = '{UOP_POP, CLS_URGENT, 1'b0, 4'd7, 4'd7};
         4'd7: w = '{UOP_POP, CLS_URGENT, 1'b0, 4'd8, 4'd8};
         4'd8: w = '{UOP_POP, CLS_EXPRESS, 1'b0, 4'd9, 4'd9};
         4'd9: w = '{UOP_POP, CLS_EXPRESS, 1'b0, 4'd10, 4'd10};
         4'd10: w = '{UOP_POP, CLS_MEDIA, 1'b0, STEP_LOOP, STEP_LOOP};
         4'd11: w = '{UOP_LOOP, CLS_URGENT, 1'b0, STEP_ROUND, STEP_FINISH};
         default: w = '{UOP_FINISH, CLS_URGENT, 1'b0, STEP_FINISH, STEP_FINISH};
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/three_class_message_scheduler.sv */
// Three-class message scheduler: queues, microcoded delivery sequencer and APB register.
// Enqueue: busy stays low, result in the cycle after the transaction; one enqueue per cycle
//   while busy is low. Update: busy stays high while the dump, march or interleave program
//   runs (interleave ends at a budget check or after an empty round); one pop per step through
//   the single RAM read port, one result per pop, last result in the first cycle busy is low.
// Results cannot be stalled. Synchronous reset empties all queues, sets frame_budget to 8.
`timescale 1ns / 1ps

module three_class_message_scheduler
   import tcms_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_mode,
   input  logic [CLS_W-1:0]      req_msg_class,
   input  logic [ID_W-1:0]       req_subject_id,
   input  logic [DATA_W-1:0]     req_payload,
   input  logic [ID_W-1:0]       req_target_id,
   input  logic [ID_W-1:0]       req_sender_id,
   // result channel
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [CLS_W-1:0]      rsp_out_class,
   output logic [ID_W-1:0]       rsp_out_subject,
   output logic [DATA_W-1:0]     rsp_out_payload,
   output logic [ID_W-1:0]       rsp_out_target,
   output logic [ID_W-1:0]       rsp_out_sender,
   output logic                  rsp_last,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
   localparam int ADDR_W   = $clog2(RAM_DEPTH);
   localparam int WORD_W   = TAG_W + DATA_W;
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [ADDR_W-1:0] BASE_EXPRESS = ADDR_W'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] BASE_MEDIA   = ADDR_W'(2 * QUEUE_DEPTH);

   // ---------------- registers ----------------
   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  before_ff, before_in;
   logic [CNT_W-1:0]  budget_ff, budget_in;
   logic [PTR_W-1:0]  head_ff [0:NUM_CLASSES-1];
   logic [PTR_W-1:0]  head_in [0:NUM_CLASSES-1];
   logic [FILL_W-1:0] fill_ff [0:NUM_CLASSES-1];
   logic [FILL_W-1:0] fill_in [0:NUM_CLASSES-1];

   logic              pop_vld_ff;
   logic [CLS_W-1:0]  pop_cls_ff;
   logic              pend_vld_ff, pend_vld_in;
   logic [CLS_W-1:0]  pend_cls_ff, pend_cls_in;
   logic [WORD_W-1:0] pend_word_ff, pend_word_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [CLS_W-1:0]  rsp_class_ff, rsp_class_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;

   // ---------------- control ----------------
   uword_type         uw;
   logic              running;
   logic              accept;
   logic              enq_accept;
   logic              upd_accept;
   logic              finishing;
   logic              pop_go;
   logic              budget_ok;
   logic [CNT_W-1:0]  budget_eff;
   logic [PTR_W-1:0]  pop_head;
   logic [FILL_W-1:0] pop_fill;
   logic [PTR_W-1:0]  enq_head;
   logic [FILL_W-1:0] enq_fill;
   logic              enq_ok;
   logic [FILL_W:0]   wr_sum;
   logic [PTR_W-1:0]  wr_idx;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] wr_word;
   logic [WORD_W-1:0] rd_word;
   logic              csr_wr;
   logic [STEP_W-1:0] entry_step;

   assign running    = (state_ff == SEQ_RUN);
   assign accept     = start && !busy;
   assign enq_accept = accept && (req_mode == MODE_ENQUEUE);
   assign upd_accept = accept && (req_mode != MODE_ENQUEUE);
   assign uw         = ucode_rom(step_ff);
   assign finishing  = running && (uw.op == UOP_FINISH);
   assign budget_eff = (budget_ff > BUDGET_CAP) ? BUDGET_CAP : budget_ff;

   // Base slot of a class in the shared queue RAM
   function automatic logic [ADDR_W-1:0] class_base(input logic [CLS_W-1:0] c);
      logic [ADDR_W-1:0] b;
      case (c)
         CLS_EXPRESS: b = BASE_EXPRESS;
         CLS_MEDIA:   b = BASE_MEDIA;
         default:     b = '0;
      endcase
      return b;
   endfunction

   // Queue selection for the current micro-step and for an enqueue
   always_comb begin
      pop_head = '0;
      pop_fill = '0;
      enq_head = '0;
      enq_fill = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (uw.cls == CLS_W'(c)) begin
            pop_head = head_ff[c];
            pop_fill = fill_ff[c];
         end
         if (req_msg_class == CLS_W'(c)) begin
            enq_head = head_ff[c];
            enq_fill = fill_ff[c];
         end
      end
   end

   assign budget_ok = !uw.use_budget || (cnt_ff < budget_eff);
   assign pop_go    = running && (uw.op == UOP_POP) && (pop_fill != '0) && budget_ok;
   assign enq_ok    = (req_msg_class < CLS_W'(NUM_CLASSES)) && (enq_fill != FULL_FILL);

   // Tail slot: head + fill, wrapped once
   always_comb begin
      wr_sum = (FILL_W+1)'(enq_head) + (FILL_W+1)'(enq_fill);
      if (wr_sum >= (FILL_W+1)'(QUEUE_DEPTH)) begin
         wr_sum = wr_sum - (FILL_W+1)'(QUEUE_DEPTH);
      end
      wr_idx = wr_sum[PTR_W-1:0];
   end

   assign wr_addr = class_base(req_msg_class) + ADDR_W'(wr_idx);
   assign rd_addr = class_base(uw.cls) + ADDR_W'(pop_head);
   assign wr_word = {req_subject_id, req_target_id, req_sender_id, req_payload};

   tcms_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (RAM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (enq_accept && enq_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // Program entry by mode
   always_comb begin
      case (req_mode)
         MODE_DUMP:  entry_step = STEP_DUMP;
         MODE_MARCH: entry_step = STEP_MARCH;
         default:    entry_step = STEP_ROUND;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (upd_accept) state_in = SEQ_RUN;
         end
         SEQ_RUN: begin
            if (uw.op == UOP_FINISH) state_in = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      case (state_ff)
         SEQ_RUN: busy = 1'b1;
         default: busy = 1'b0;
      endcase
   end

   // Step counter, delivery count and round marker
   always_comb begin
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      before_in = before_ff;
      if (upd_accept) begin
         step_in = entry_step;
         cnt_in  = '0;
      end else if (running) begin
         case (uw.op)
            UOP_POP: begin
               step_in = pop_go ? uw.jmp_hit : uw.jmp_miss;
               if (pop_go) cnt_in = cnt_ff + 1'b1;
            end
            UOP_ROUND: begin
               step_in   = (cnt_ff >= budget_eff) ? uw.jmp_miss : uw.jmp_hit;
               before_in = cnt_ff;
            end
            UOP_LOOP: begin
               step_in = (cnt_ff != before_ff) ? uw.jmp_hit : uw.jmp_miss;
            end
            default: step_in = step_ff;
         endcase
      end
   end

   // Queue pointers
   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         head_in[c] = head_ff[c];
         fill_in[c] = fill_ff[c];
         if (enq_accept && enq_ok && (req_msg_class == CLS_W'(c))) begin
            fill_in[c] = fill_ff[c] + 1'b1;
         end
         if (pop_go && (uw.cls == CLS_W'(c))) begin
            fill_in[c] = fill_ff[c] - 1'b1;
            head_in[c] = (head_ff[c] == LAST_PTR) ? '0 : head_ff[c] + 1'b1;
         end
      end
   end

   // One-deep pending result so the final delivery can carry last
   always_comb begin
      pend_vld_in  = pend_vld_ff;
      pend_cls_in  = pend_cls_ff;
      pend_word_in = pend_word_ff;
      if (upd_accept || finishing) begin
         pend_vld_in = 1'b0;
      end else if (pop_vld_ff) begin
         pend_vld_in  = 1'b1;
         pend_cls_in  = pop_cls_ff;
         pend_word_in = rd_word;
      end
   end

   // Result register
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      if (enq_accept) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = enq_ok ? ST_ACCEPTED : ST_DROPPED;
         rsp_class_in  = req_msg_class;
         rsp_word_in   = '0;
         rsp_last_in   = 1'b1;
      end else if (pop_vld_ff && pend_vld_ff) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = ST_DELIVERED;
         rsp_class_in  = pend_cls_ff;
         rsp_word_in   = pend_word_ff;
         rsp_last_in   = 1'b0;
      end else if (finishing) begin
         rsp_strobe_in = 1'b1;
         rsp_last_in   = 1'b1;
         if (pend_vld_ff) begin
            rsp_status_in = ST_DELIVERED;
            rsp_class_in  = pend_cls_ff;
            rsp_word_in   = pend_word_ff;
         end else begin
            rsp_status_in = ST_NONE;
            rsp_class_in  = CLS_URGENT;
            rsp_word_in   = '0;
         end
      end
   end

   // Register port
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      budget_in = budget_ff;
      if (csr_wr && (paddr[2] == REG_FRAME_BUDGET)) begin
         budget_in = pwdata[CNT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_FRAME_BUDGET) ?
                   {{(CSR_DATA_W-CNT_W){1'b0}}, budget_ff} : '0;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         step_ff       <= STEP_FINISH;
         cnt_ff        <= '0;
         before_ff     <= '0;
         budget_ff     <= BUDGET_RESET;
         pop_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= '0;
            fill_ff[c] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cnt_ff        <= cnt_in;
         before_ff     <= before_in;
         budget_ff     <= budget_in;
         pop_vld_ff    <= pop_go;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c] <= head_in[c];
            fill_ff[c] <= fill_in[c];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pop_cls_ff    <= uw.cls;
      pend_cls_ff   <= pend_cls_in;
      pend_word_ff  <= pend_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_class   = rsp_class_ff;
   assign rsp_out_subject = rsp_word_ff[DATA_W+TAG_W-1 -: ID_W];
   assign rsp_out_target  = rsp_word_ff[DATA_W+ID_W+ID_W-1 -: ID_W];
   assign rsp_out_sender  = rsp_word_ff[DATA_W+ID_W-1 -: ID_W];
   assign rsp_out_payload = rsp_word_ff[DATA_W-1:0];
   assign rsp_last        = rsp_last_ff;

endmodule

/* rtl/core/tcms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcms_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* dv/tcms_checker.sv */
// Checker for the three-class message scheduler: predicts results and compares them.
`timescale 1ns / 1ps

module tcms_checker
   import tcms_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   input  logic                  busy,
   input  logic [1:0]            req_mode,
   input  logic [CLS_W-1:0]      req_msg_class,
   input  logic [ID_W-1:0]       req_subject_id,
   input  logic [DATA_W-1:0]     req_payload,
   input  logic [ID_W-1:0]       req_target_id,
   input  logic [ID_W-1:0]       req_sender_id,
   // result channel
   input  logic                  rsp_strobe,
   input  logic [1:0]            rsp_status,
   input  logic [CLS_W-1:0]      rsp_out_class,
   input  logic [ID_W-1:0]       rsp_out_subject,
   input  logic [DATA_W-1:0]     rsp_out_payload,
   input  logic [ID_W-1:0]       rsp_out_target,
   input  logic [ID_W-1:0]       rsp_out_sender,
   input  logic                  rsp_last,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   // status to the testbench top
   output int                    fail_count,
   output int                    pending
);

   localparam logic [CSR_ADDR_W-1:0] BUDGET_ADDR = {REG_FRAME_BUDGET, 2'b00};

   typedef struct packed {
      logic [ID_W-1:0]   subject;
      logic [DATA_W-1:0] payload;
      logic [ID_W-1:0]   target;
      logic [ID_W-1:0]   sender;
   } message_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [CLS_W-1:0] cls;
      message_type      msg;
      logic             last;
   } delivery_type;

   // Shadow copy of the class queues and the budget register
   message_type class_slots [NUM_CLASSES][QUEUE_DEPTH];
   int         class_head [NUM_CLASSES];
   int         class_fill [NUM_CLASSES];
   logic [CNT_W-1:0] budget_reg;
   int         delivered;

   delivery_type due_results [$];
   delivery_type got;
   delivery_type want;

   initial fail_count = 0;
   initial pending = 0;

   // Pops the head of one class into the expected results; 0 when empty
   function automatic bit pop_class(input int c);
      delivery_type d;
      if (class_fill[c] == 0)
         return 1'b0;
      d.status = ST_DELIVERED;
      d.cls    = CLS_W'(c);
      d.msg    = class_slots[c][class_head[c]];
      d.last   = 1'b0;
      due_results.push_back(d);
      class_head[c] = (class_head[c] + 1) % QUEUE_DEPTH;
      class_fill[c]--;
      delivered++;
      return 1'b1;
   endfunction

   // Works out the results of one accepted command
   task automatic schedule_command(input logic [1:0] mode, input logic [CLS_W-1:0] cls,
                                   input message_type m);
      delivery_type d;
      int limit;
      int round_start;
      delivered = 0;
      limit = (budget_reg > BUDGET_CAP) ? int'(BUDGET_CAP) : int'(budget_reg);
      d = '0;
      case (mode)
         MODE_ENQUEUE: begin
            d.cls  = cls;
            d.last = 1'b1;
            if (cls < NUM_CLASSES && class_fill[cls] < QUEUE_DEPTH) begin
               class_slots[cls][(class_head[cls] + class_fill[cls]) % QUEUE_DEPTH] = m;
               class_fill[cls]++;
               d.status = ST_ACCEPTED;
            end else begin
               d.status = ST_DROPPED;
            end
            due_results.push_back(d);
         end
         MODE_DUMP: begin
            while (pop_class(CLS_URGENT)) begin
            end
         end
         MODE_MARCH: begin
            for (int c = 0; c < NUM_CLASSES; c++)
               while (delivered < limit && pop_class(c)) begin
               end
         end
         default: begin
            // interleave: count accumulates, budget checked only between rounds
            while (delivered < limit) begin
               round_start = delivered;
               void'(pop_class(CLS_URGENT));
               void'(pop_class(CLS_URGENT));
               void'(pop_class(CLS_URGENT));
               void'(pop_class(CLS_EXPRESS));
               void'(pop_class(CLS_EXPRESS));
               void'(pop_class(CLS_MEDIA));
               if (delivered == round_start)
                  break;
            end
         end
      endcase
      if (mode != MODE_ENQUEUE) begin
         if (delivered == 0) begin
            d.status = ST_NONE;
            d.last   = 1'b1;
            due_results.push_back(d);
         end else begin
            d = due_results.pop_back();
            d.last = 1'b1;
            due_results.push_back(d);
         end
      end
   endtask

   // Monitor: compare results, predict accepted commands, track register writes
   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            class_head[c] = 0;
            class_fill[c] = 0;
         end
         budget_reg = BUDGET_RESET;
         due_results.delete();
      end else begin
         if (rsp_strobe) begin
            got.status      = rsp_status;
            got.cls         = rsp_out_class;
            got.msg.subject = rsp_out_subject;
            got.msg.payload = rsp_out_payload;
            got.msg.target  = rsp_out_target;
            got.msg.sender  = rsp_out_sender;
            got.last        = rsp_last;
            if (due_results.size() == 0) begin
               if (fail_count < 10)
                  $display({"%0t: unexpected result st=%0d cls=%0d subj=%h pay=%h",
                            " tgt=%h snd=%h last=%0b"},
                           $time, got.status, got.cls, got.msg.subject, got.msg.payload,
                           got.msg.target, got.msg.sender, got.last);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (got != want) begin
                  if (fail_count < 10) begin
                     $display({"%0t: mismatch expected st=%0d cls=%0d subj=%h pay=%h",
                               " tgt=%h snd=%h last=%0b"},
                              $time, want.status, want.cls, want.msg.subject,
                              want.msg.payload, want.msg.target, want.msg.sender,
                              want.last);
                     $display({"%0t:            actual st=%0d cls=%0d subj=%h pay=%h",
                               " tgt=%h snd=%h last=%0b"},
                              $time, got.status, got.cls, got.msg.subject,
                              got.msg.payload, got.msg.target, got.msg.sender,
                              got.last);
                  end
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            schedule_command(req_mode, req_msg_class,
                             '{req_subject_id, req_payload, req_target_id, req_sender_id});
         if (psel && penable && pwrite && pready && paddr == BUDGET_ADDR)
            budget_reg = pwdata[CNT_W-1:0];
      end
      pending <= due_results.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top for the three-class message scheduler: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb;
   import tcms_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_ADDR_W-1:0] BUDGET_ADDR = {REG_FRAME_BUDGET, 2'b00};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_mode = MODE_ENQUEUE;
   logic [CLS_W-1:0]      req_msg_class = CLS_URGENT;
   logic [ID_W-1:0]       req_subject_id = '0;
   logic [DATA_W-1:0]     req_payload = '0;
   logic [ID_W-1:0]       req_target_id = '0;
   logic [ID_W-1:0]       req_sender_id = '0;
   logic                  rsp_strobe;
   logic [1:0]            rsp_status;
   logic [CLS_W-1:0]      rsp_out_class;
   logic [ID_W-1:0]       rsp_out_subject;
   logic [DATA_W-1:0]     rsp_out_payload;
   logic [ID_W-1:0]       rsp_out_target;
   logic [ID_W-1:0]       rsp_out_sender;
   logic                  rsp_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int idle_pct = 0;
   int commands_left;

   three_class_message_scheduler u_top (.*);

   tcms_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_mode, .req_msg_class, .req_subject_id, .req_payload, .req_target_id, .req_sender_id,
      .rsp_strobe, .rsp_status, .rsp_out_class, .rsp_out_subject, .rsp_out_payload,
      .rsp_out_target, .rsp_out_sender, .rsp_last,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .pending
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One command transaction, with a random sender gap ahead of it
   task automatic send_message(input logic [1:0] mode, input logic [CLS_W-1:0] cls,
                               input logic [ID_W-1:0] subj, input logic [DATA_W-1:0] pay,
                               input logic [ID_W-1:0] tgt, input logic [ID_W-1:0] snd);
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= mode;
      req_msg_class  <= cls;
      req_subject_id <= subj;
      req_payload    <= pay;
      req_target_id  <= tgt;
      req_sender_id  <= snd;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      commands_left--;
   endtask

   task automatic random_command(input logic [1:0] mode, input logic [CLS_W-1:0] cls);
      send_message(mode, cls, ID_W'($urandom), {$urandom, $urandom},
                   ID_W'($urandom), ID_W'($urandom));
   endtask

   // Drop start and wait until the block has gone quiet
   task automatic settle;
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_budget(input logic [CSR_DATA_W-1:0] value);
      bit ready;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= BUDGET_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = pready;
         @(posedge clock);
      end while (!ready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly enqueue bursts followed by delivery passes; floods push a class to full
   task automatic random_phase(input int count);
      int pick;
      logic [CLS_W-1:0] cls;
      commands_left = count;
      while (commands_left > 0) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            cls = CLS_W'($urandom_range(NUM_CLASSES - 1));
            repeat (17 + $urandom_range(3)) random_command(MODE_ENQUEUE, cls);
         end else if (pick < 58) begin
            cls = ($urandom_range(99) < 4) ? CLS_W'(3) : CLS_W'($urandom_range(NUM_CLASSES - 1));
            random_command(MODE_ENQUEUE, cls);
         end else if (pick < 68) begin
            random_command(MODE_DUMP, CLS_W'($urandom));
         end else if (pick < 84) begin
            random_command(MODE_MARCH, CLS_W'($urandom));
         end else begin
            random_command(MODE_INTERLEAVE, CLS_W'($urandom));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty passes, field extremes, bad class, then mixed queues (budget 8)
      random_command(MODE_DUMP, CLS_URGENT);
      random_command(MODE_MARCH, CLS_EXPRESS);
      random_command(MODE_INTERLEAVE, CLS_MEDIA);
      send_message(MODE_ENQUEUE, CLS_URGENT, '1, '1, '1, '1);
      send_message(MODE_ENQUEUE, CLS_EXPRESS, '0, '0, '0, '0);
      send_message(MODE_ENQUEUE, CLS_MEDIA, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   16'hAAAA, 16'h5555);
      send_message(MODE_ENQUEUE, CLS_W'(3), '1, '1, '1, '1);
      random_command(MODE_MARCH, CLS_W'(3));
      repeat (5) random_command(MODE_ENQUEUE, CLS_URGENT);
      repeat (3) random_command(MODE_ENQUEUE, CLS_EXPRESS);
      repeat (2) random_command(MODE_ENQUEUE, CLS_MEDIA);
      // two rounds: the count passes the budget inside the second one
      random_command(MODE_INTERLEAVE, CLS_URGENT);
      repeat (2) random_command(MODE_ENQUEUE, CLS_URGENT);
      random_command(MODE_DUMP, CLS_MEDIA);
      random_command(MODE_ENQUEUE, CLS_EXPRESS);
      random_command(MODE_MARCH, CLS_URGENT);
      random_command(MODE_DUMP, CLS_URGENT);

      // Budget of one, no idling
      settle();
      write_budget(CSR_DATA_W'(1));
      idle_pct = 0;
      random_phase(35);

      // Largest budget, sender idle often
      settle();
      write_budget(CSR_DATA_W'(32));
      idle_pct = 46;
      random_phase(40);

      // Budget zero with junk in the unused upper bits
      settle();
      write_budget({26'($urandom), 6'd0});
      idle_pct = 34;
      random_phase(20);

      // Field maximum, acts as the cap
      settle();
      write_budget(CSR_DATA_W'(63));
      idle_pct = 0;
      random_phase(40);

      // Just over the cap
      settle();
      write_budget(CSR_DATA_W'(33));
      idle_pct = 46;
      random_phase(35);

      // Random in-range budget
      settle();
      write_budget({26'($urandom), 6'($urandom_range(32, 1))});
      idle_pct = 34;
      random_phase(40);

      // Drain and give the block time to finish
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* three_class_message_scheduler.f */
rtl/core/tcms_pkg.sv
rtl/core/tcms_ram.sv
rtl/core/three_class_message_scheduler.sv
dv/tcms_checker.sv
dv/tb.sv
